// ===== rtl/vtp_pkg.sv =====
// vtp_pkg: shared types and constants of the vertex trigger primitive engine
// no dependencies; used by the interfaces and every module in rtl but vtp_divider
package vtp_pkg;

    localparam int SMP_W   = 14;
    localparam logic [SMP_W-1:0] SMP_MAX = 14'h3fff;
    localparam int ADC_DEPTH  = 1024;
    localparam int SLEW_DEPTH = 4096;

    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_ADC_WR   = 2'd1;
    localparam logic [1:0] REQ_SLEW_WR  = 2'd2;

    localparam logic [2:0] CFG_HIT_LOW  = 3'd0;
    localparam logic [2:0] CFG_HIT_HIGH = 3'd1;
    localparam logic [2:0] CFG_WIN_NAR  = 3'd2;
    localparam logic [2:0] CFG_WIN_MID  = 3'd3;
    localparam logic [2:0] CFG_WIN_WIDE = 3'd4;
    localparam logic [2:0] CFG_SPE      = 3'd5;
    localparam logic [2:0] CFG_DELAY    = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [6:0]  pair_index;
        logic [5:0]  sample_index;
        logic [15:0] time_sample;
        logic [15:0] charge_sample;
        logic [11:0] table_address;
        logic [9:0]  table_data;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  hits_north;
        logic [6:0]  hits_south;
        logic [14:0] time_sum_north;
        logic [14:0] time_sum_south;
        logic [14:0] time_avg_north;
        logic [14:0] time_avg_south;
        logic [7:0]  time_rem_north;
        logic [7:0]  time_rem_south;
        logic [8:0]  vertex_diff;
        logic [9:0]  vertex_sum;
        logic [9:0]  trigger_bits;
        logic [5:0]  slice_index;
    } t_out_item;

    typedef struct packed {
        logic [6:0] hit_low;
        logic [6:0] hit_high;
        logic [8:0] win_narrow;
        logic [8:0] win_middle;
        logic [8:0] win_wide;
        logic [5:0] samples_per_event;
        logic [2:0] delay;
    } t_cfg;

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_ADC_WR,
        K_SLEW_WR
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [6:0]       pair;
        logic [5:0]       smp;
        logic [SMP_W-1:0] tval;
        logic [SMP_W-1:0] qval;
        logic [11:0]      addr;
        logic [9:0]       data;
        logic             smp_valid;
        logic             last;
        logic             north;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIFF,
        S_SLEW,
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== rtl/vtp_ifs.sv =====
// vtp_in_if / vtp_out_if: valid-ready channels carrying input and result beats
// depends on vtp_pkg
interface vtp_in_if;
    import vtp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface vtp_out_if;
    import vtp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/vtp_queue.sv =====
// vtp_queue: two-entry command queue between front and back
// depends on vtp_pkg
module vtp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vtp_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output vtp_pkg::t_cmd o_cmd
);
    import vtp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ===== rtl/vtp_front.sv =====
// vtp_front: accepts input beats, drops unused ones, clamps and classifies samples
// depends on vtp_pkg and vtp_queue
module vtp_front #(
    parameter int NUM_PAIRS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vtp_in_if.sink        i_in,
    input  vtp_pkg::t_cfg i_cfg,
    input  logic          i_clr_busy,
    input  logic          i_pop,
    output logic          o_valid,
    output vtp_pkg::t_cmd o_cmd
);
    import vtp_pkg::*;

    t_cmd       cmd;
    logic       keep;
    logic       full;
    logic       accept;
    logic [6:0] smp_p1;

    function automatic logic [SMP_W-1:0] clamp14(input logic [15:0] v);
        return (v > 16'(SMP_MAX)) ? SMP_MAX : v[SMP_W-1:0];
    endfunction

    assign i_in.ready = !full && !i_clr_busy;
    assign accept     = i_in.valid && i_in.ready;
    assign smp_p1     = {1'b0, i_in.item.sample_index} + 7'd1;

    always_comb begin
        cmd           = '0;
        cmd.pair      = i_in.item.pair_index;
        cmd.smp       = i_in.item.sample_index;
        cmd.tval      = clamp14(i_in.item.time_sample);
        cmd.qval      = clamp14(i_in.item.charge_sample);
        cmd.addr      = i_in.item.table_address;
        cmd.data      = i_in.item.table_data;
        cmd.smp_valid = (i_in.item.sample_index >= 6'(i_cfg.delay))
                        && (smp_p1 < {1'b0, i_cfg.samples_per_event});
        cmd.last      = ({1'b0, i_in.item.pair_index} == 8'(NUM_PAIRS - 1));
        cmd.north     = ({1'b0, i_in.item.pair_index} < 8'(NUM_PAIRS / 2));
        keep          = 1'b0;
        cmd.kind      = K_SAMPLE;
        unique case (i_in.item.req_type)
            REQ_SAMPLE: begin
                keep     = ({1'b0, i_in.item.pair_index} < 8'(NUM_PAIRS));
                cmd.kind = K_SAMPLE;
            end
            REQ_ADC_WR: begin
                keep     = 1'b1;
                cmd.kind = K_ADC_WR;
            end
            REQ_SLEW_WR: begin
                keep     = 1'b1;
                cmd.kind = K_SLEW_WR;
            end
            default: keep = 1'b0;
        endcase
    end

    vtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && keep),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_valid (o_valid),
        .o_cmd   (o_cmd)
    );
endmodule

// ===== rtl/vtp_divider.sv =====
// vtp_divider: restoring divider, 15-bit sum by 7-bit hit count, one bit per cycle
// depends on nothing
module vtp_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [14:0] i_dividend,
    input  logic [6:0]  i_divisor,
    output logic        o_busy,
    output logic [14:0] o_quot,
    output logic [6:0]  o_rem
);
    logic [14:0] r_quo;
    logic [6:0]  r_rem;
    logic [6:0]  r_dvs;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [7:0]  shifted;
    logic        fits;

    assign shifted = {r_rem, r_quo[14]};
    assign fits    = (shifted >= {1'b0, r_dvs});
    assign o_busy  = r_busy;
    assign o_quot  = r_quo;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 7'(shifted - {1'b0, r_dvs}) : shifted[6:0];
            r_quo <= {r_quo[13:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 4'd14;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/vtp_back.sv =====
// vtp_back: history, table and accumulation sequencer plus slice result stage
// depends on vtp_pkg and vtp_divider
module vtp_back #(
    parameter int NUM_PAIRS     = 128,
    parameter int HISTORY_DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vtp_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  vtp_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_clr_busy,
    vtp_out_if.source     o_out
);
    import vtp_pkg::*;

    localparam int HT   = NUM_PAIRS * HISTORY_DEPTH;
    localparam int AW   = $clog2(HT);
    localparam int SLW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int MODN = 64 + 8 * HISTORY_DEPTH;
    localparam int MIW  = $clog2(MODN);

    t_state r_state, n_state;

    logic [27:0] hist_mem [HT];
    logic [9:0]  adc_mem  [ADC_DEPTH];
    logic [8:0]  slew_mem [SLEW_DEPTH];

    logic [SLW-1:0] mod_lut [MODN];

    logic [11:0] r_clr_cnt;
    t_cmd        r_cmd;
    logic [27:0] r_hist_rd;
    logic        r_byp;
    logic [9:0]  r_adc_t, r_adc_q;
    logic [8:0]  r_slew;
    logic        r_hit;
    logic [6:0]  r_hn, r_hs, r_res_hn, r_res_hs;
    logic [14:0] r_tn, r_ts, r_res_tn, r_res_ts;
    logic        r_out_valid;
    t_out_item   r_out;

    logic          hist_we, adc_we, slew_we;
    logic [AW-1:0] hist_wa, hist_ra, cur_base;
    logic [27:0]   hist_wd, then_v;
    logic [9:0]    adc_wa, adc_wd, adc_ra_t, adc_ra_q;
    logic [11:0]   slew_wa, slew_ra;
    logic [8:0]    slew_wd;
    logic [MIW-1:0] dly_idx;
    logic [SMP_W-1:0] dt, dq;
    logic          add_n, add_s, div_start, out_load;
    logic [7:0]    hn_sum, hs_sum;
    logic [15:0]   tn_sum, ts_sum;
    logic [6:0]    hn_new, hs_new;
    logic [14:0]   tn_new, ts_new;
    logic          dn_busy, ds_busy;
    logic [14:0]   qn, qs, an, as_v;
    logic [6:0]    rn7, rs7;
    logic [15:0]   vs16;
    logic [8:0]    vdiff;
    logic          low_both, high_both;
    t_out_item     res;

    for (genvar g = 0; g < MODN; g++) begin : g_mod
        assign mod_lut[g] = SLW'(g % HISTORY_DEPTH);
    end

    // history slots of the head command: current slot and the delayed one
    assign cur_base = AW'(AW'(i_q_cmd.pair) * AW'(HISTORY_DEPTH));
    assign dly_idx  = MIW'({2'b0, i_q_cmd.smp}) + MIW'(8 * HISTORY_DEPTH)
                      - MIW'(i_cfg.delay);
    assign hist_ra  = cur_base + AW'(mod_lut[dly_idx]);

    assign o_clr_busy = (r_state == S_CLR);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr_cnt == 12'hfff) n_state = S_IDLE;
            S_IDLE: if (i_q_valid && i_q_cmd.kind == K_SAMPLE) n_state = S_DIFF;
            S_DIFF: n_state = S_SLEW;
            S_SLEW: n_state = S_ACC;
            S_ACC: begin
                if (r_cmd.last && r_cmd.smp_valid) n_state = S_DIV;
                else n_state = S_IDLE;
            end
            S_DIV:  if (!dn_busy && !ds_busy) n_state = S_OUT;
            S_OUT:  if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop   = 1'b0;
        hist_we   = 1'b0;
        hist_wa   = cur_base + AW'(mod_lut[MIW'(i_q_cmd.smp)]);
        hist_wd   = {i_q_cmd.qval, i_q_cmd.tval};
        adc_we    = 1'b0;
        adc_wa    = i_q_cmd.addr[9:0];
        adc_wd    = i_q_cmd.data;
        slew_we   = 1'b0;
        slew_wa   = i_q_cmd.addr;
        slew_wd   = i_q_cmd.data[8:0];
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_CLR: begin
                hist_we = ({1'b0, r_clr_cnt} < 13'(HT));
                hist_wa = r_clr_cnt[AW-1:0];
                hist_wd = '0;
                adc_we  = (r_clr_cnt[11:10] == 2'b00);
                adc_wa  = r_clr_cnt[9:0];
                adc_wd  = r_clr_cnt[9:0];
                slew_we = 1'b1;
                slew_wa = r_clr_cnt;
                slew_wd = r_clr_cnt[8:0];
            end
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        K_SAMPLE:  hist_we = 1'b1;
                        K_ADC_WR:  adc_we  = (i_q_cmd.addr[11:10] == 2'b00);
                        K_SLEW_WR: slew_we = 1'b1;
                        default:   ;
                    endcase
                end
            end
            S_ACC: div_start = r_cmd.last && r_cmd.smp_valid;
            S_OUT: out_load  = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_wa] <= hist_wd;
        end
        r_hist_rd <= hist_mem[hist_ra];
    end

    always_ff @(posedge i_clk) begin
        if (adc_we) begin
            adc_mem[adc_wa] <= adc_wd;
        end
        r_adc_t <= adc_mem[adc_ra_t];
        r_adc_q <= adc_mem[adc_ra_q];
    end

    always_ff @(posedge i_clk) begin
        if (slew_we) begin
            slew_mem[slew_wa] <= slew_wd;
        end
        r_slew <= slew_mem[slew_ra];
    end

    // delayed slot equal to the written one reads the current sample
    assign then_v   = r_byp ? {r_cmd.qval, r_cmd.tval} : r_hist_rd;
    assign dt       = (r_cmd.tval > then_v[13:0]) ? r_cmd.tval - then_v[13:0] : '0;
    assign dq       = (r_cmd.qval > then_v[27:14]) ? r_cmd.qval - then_v[27:14] : '0;
    assign adc_ra_t = dt[13:4];
    assign adc_ra_q = dq[13:4];
    assign slew_ra  = {r_adc_q[9:7], r_adc_t[8:0]};

    // saturating side sums
    assign add_n  = r_cmd.smp_valid && r_cmd.north;
    assign add_s  = r_cmd.smp_valid && !r_cmd.north;
    assign hn_sum = {1'b0, r_hn} + 8'(r_hit);
    assign hs_sum = {1'b0, r_hs} + 8'(r_hit);
    assign tn_sum = {1'b0, r_tn} + 16'(r_slew);
    assign ts_sum = {1'b0, r_ts} + 16'(r_slew);
    assign hn_new = !add_n ? r_hn : (hn_sum[7] ? 7'h7f : hn_sum[6:0]);
    assign hs_new = !add_s ? r_hs : (hs_sum[7] ? 7'h7f : hs_sum[6:0]);
    assign tn_new = !add_n ? r_tn : (tn_sum[15] ? 15'h7fff : tn_sum[14:0]);
    assign ts_new = !add_s ? r_ts : (ts_sum[15] ? 15'h7fff : ts_sum[14:0]);

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_cmd <= i_q_cmd;
            r_byp <= (hist_ra == hist_wa);
        end
        if (r_state == S_SLEW) begin
            r_hit <= r_adc_t[9];
        end
        if (div_start) begin
            r_res_hn <= hn_new;
            r_res_hs <= hs_new;
            r_res_tn <= tn_new;
            r_res_ts <= ts_new;
        end
        if (out_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_hn        <= '0;
            r_hs        <= '0;
            r_tn        <= '0;
            r_ts        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + 12'd1;
            end
            if (r_state == S_ACC) begin
                if (r_cmd.last) begin
                    r_hn <= '0;
                    r_hs <= '0;
                    r_tn <= '0;
                    r_ts <= '0;
                end else begin
                    r_hn <= hn_new;
                    r_hs <= hs_new;
                    r_tn <= tn_new;
                    r_ts <= ts_new;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    vtp_divider u_div_n (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (tn_new),
        .i_divisor  (hn_new),
        .o_busy     (dn_busy),
        .o_quot     (qn),
        .o_rem      (rn7)
    );

    vtp_divider u_div_s (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ts_new),
        .i_divisor  (hs_new),
        .o_busy     (ds_busy),
        .o_quot     (qs),
        .o_rem      (rs7)
    );

    // slice result
    assign an        = (r_res_hn == '0) ? 15'd255 : qn;
    assign as_v      = (r_res_hs == '0) ? 15'd255 : qs;
    assign vs16      = {1'b0, an} + {1'b0, as_v};
    assign vdiff     = (an > as_v) ? 9'(an - as_v) : 9'(as_v - an);
    assign low_both  = (r_res_hn >= i_cfg.hit_low) && (r_res_hs >= i_cfg.hit_low);
    assign high_both = (r_res_hn >= i_cfg.hit_high) && (r_res_hs >= i_cfg.hit_high);

    always_comb begin
        res.hits_north     = r_res_hn;
        res.hits_south     = r_res_hs;
        res.time_sum_north = r_res_tn;
        res.time_sum_south = r_res_ts;
        res.time_avg_north = an;
        res.time_avg_south = as_v;
        res.time_rem_north = (r_res_hn == '0) ? 8'hff : {1'b0, rn7};
        res.time_rem_south = (r_res_hs == '0) ? 8'hff : {1'b0, rs7};
        res.vertex_diff    = vdiff;
        res.vertex_sum     = vs16[9:0];
        res.trigger_bits   = {high_both && (vdiff <= i_cfg.win_wide),
                              high_both && (vdiff <= i_cfg.win_middle),
                              high_both && (vdiff <= i_cfg.win_narrow),
                              low_both && (vdiff <= i_cfg.win_wide),
                              low_both && (vdiff <= i_cfg.win_middle),
                              low_both && (vdiff <= i_cfg.win_narrow),
                              r_res_hs >= i_cfg.hit_high,
                              r_res_hn >= i_cfg.hit_high,
                              r_res_hs >= i_cfg.hit_low,
                              r_res_hn >= i_cfg.hit_low};
        res.slice_index    = r_cmd.smp - 6'(i_cfg.delay);
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_q_pop)
        else $error("queue popped during table clearing");

    a_load_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == S_OUT) && !dn_busy && !ds_busy)
        else $error("result loaded outside result state");

    a_div_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == S_DIV) && dn_busy && ds_busy)
        else $error("dividers not started at slice end");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && !dn_busy && !ds_busy |=> (r_state == S_OUT))
        else $error("sequencer missed divider completion");
endmodule

// ===== rtl/vertex_trigger_primitive_engine_top.sv =====
// vertex_trigger_primitive_engine_top: config registers and front/back hookup
// depends on vtp_pkg, vtp_ifs, vtp_front, vtp_back
//
// Usage: i_in carries one beat per sample pair or table write; o_out carries
// one result beat per valid sample of the last pair of a slice. Config writes
// use i_cfg_valid/o_cfg_ready with a register index (0..6) and data; o_cfg_ready
// is always high and writes are expected only while the block is idle.
// A sample beat passes the back sequencer states in order (queue pop with
// history read, ADC table read, slewing table read, accumulate). A slice-ending
// beat then waits in the two bit-serial dividers and loads the result register.
// Table writes are done in the idle state as they are popped. The back
// sequencer handles one beat at a time. A two-entry queue lets i_in keep
// accepting while the back part works, and the result register lets work go
// on while o_out is stalled.
// After reset a clearing pass over all table addresses loads the history with
// zero and both tables with default contents; i_in.ready stays low meanwhile.
// A stalled receiver holds the result and eventually blocks the next slice end.
module vertex_trigger_primitive_engine_top #(
    parameter int NUM_PAIRS     = 128,
    parameter int HISTORY_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vtp_in_if.sink     i_in,
    vtp_out_if.source  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import vtp_pkg::*;

    t_cfg r_cfg;
    logic q_valid, q_pop, clr_busy;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hit_low           <= 7'd2;
            r_cfg.hit_high          <= 7'd5;
            r_cfg.win_narrow        <= 9'd10;
            r_cfg.win_middle        <= 9'd20;
            r_cfg.win_wide          <= 9'd30;
            r_cfg.samples_per_event <= 6'd31;
            r_cfg.delay             <= 3'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HIT_LOW:  r_cfg.hit_low           <= i_cfg_data[6:0];
                CFG_HIT_HIGH: r_cfg.hit_high          <= i_cfg_data[6:0];
                CFG_WIN_NAR:  r_cfg.win_narrow        <= i_cfg_data;
                CFG_WIN_MID:  r_cfg.win_middle        <= i_cfg_data;
                CFG_WIN_WIDE: r_cfg.win_wide          <= i_cfg_data;
                CFG_SPE:      r_cfg.samples_per_event <= i_cfg_data[5:0];
                CFG_DELAY:    r_cfg.delay             <= i_cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    vtp_front #(
        .NUM_PAIRS (NUM_PAIRS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_clr_busy (clr_busy),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd)
    );

    vtp_back #(
        .NUM_PAIRS     (NUM_PAIRS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_clr_busy (clr_busy),
        .o_out      (o_out)
    );
endmodule

// ===== tb/testbench.sv =====
// testbench for vertex_trigger_primitive_engine_top: random and directed sample/table beats
// depends on vtp_pkg, vtp_ifs and the rtl top; carries its own predictor of the results
`timescale 1ns / 1ps

module testbench;
    import vtp_pkg::*;

    localparam int PAIRS = 128;
    localparam int HDEPTH = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    vtp_in_if in_ch();
    vtp_out_if out_ch();

    vertex_trigger_primitive_engine_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [27:0] hist_mem [PAIRS*HDEPTH];
    logic [9:0] adc_lut [1024];
    logic [8:0] slew_lut [4096];
    int unsigned hits_n, hits_s, tsum_n, tsum_s;
    t_cfg cur_cfg;

    t_in_item pending_beats[$];
    t_out_item results_due[$];
    int fails = 0;
    int idle_mode = 0;

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        fails++;
    endtask

    function automatic void queue_beat(t_in_item it);
        pending_beats.insert(pending_beats.size(), it);
    endfunction

    function automatic logic [13:0] clamp_raw(logic [15:0] v);
        return (v > 16'h3fff) ? 14'h3fff : v[13:0];
    endfunction

    function automatic int unsigned pos_sub(int unsigned a, int unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic void predict_beat(t_in_item it);
        logic [27:0] now_w, then_w;
        int unsigned base, dt, dq, tq, tt, slewed, hit;
        int unsigned avg_n, avg_s, rem_n, rem_s, vd, trig;
        bit ok, lowb, highb;
        t_out_item r;
        case (it.req_type)
            REQ_ADC_WR: begin
                if (it.table_address < 1024) adc_lut[it.table_address[9:0]] = it.table_data;
                return;
            end
            REQ_SLEW_WR: begin
                slew_lut[it.table_address] = it.table_data[8:0];
                return;
            end
            REQ_SAMPLE: ;
            default: return;
        endcase
        if (it.pair_index >= PAIRS) return;
        base = it.pair_index * HDEPTH;
        now_w = {clamp_raw(it.charge_sample), clamp_raw(it.time_sample)};
        hist_mem[base + it.sample_index % HDEPTH] = now_w;
        then_w = hist_mem[base + (it.sample_index + HDEPTH*8 - cur_cfg.delay) % HDEPTH];
        ok = (it.sample_index >= cur_cfg.delay) && (it.sample_index + 1 < cur_cfg.samples_per_event);
        if (ok) begin
            dt = pos_sub(now_w[13:0], then_w[13:0]);
            dq = pos_sub(now_w[27:14], then_w[27:14]);
            tq = adc_lut[(dq >> 4) & 10'h3ff];
            tt = adc_lut[(dt >> 4) & 10'h3ff];
            hit = (tt >> 9) & 1;
            slewed = slew_lut[((((tq & 'h380) >> 7) << 9) + (tt & 'h1ff)) & 'hfff];
            if (it.pair_index < PAIRS/2) begin
                hits_n = (hits_n + hit > 127) ? 127 : hits_n + hit;
                tsum_n = (tsum_n + slewed > 32767) ? 32767 : tsum_n + slewed;
            end else begin
                hits_s = (hits_s + hit > 127) ? 127 : hits_s + hit;
                tsum_s = (tsum_s + slewed > 32767) ? 32767 : tsum_s + slewed;
            end
        end
        if (it.pair_index != PAIRS-1) return;
        if (ok) begin
            avg_n = hits_n ? tsum_n / hits_n : 'hff;
            rem_n = hits_n ? tsum_n % hits_n : 'hff;
            avg_s = hits_s ? tsum_s / hits_s : 'hff;
            rem_s = hits_s ? tsum_s % hits_s : 'hff;
            vd = ((avg_n > avg_s) ? avg_n - avg_s : avg_s - avg_n) & 'h1ff;
            lowb = hits_n >= cur_cfg.hit_low && hits_s >= cur_cfg.hit_low;
            highb = hits_n >= cur_cfg.hit_high && hits_s >= cur_cfg.hit_high;
            trig = 0;
            trig[0] = hits_n >= cur_cfg.hit_low;
            trig[1] = hits_s >= cur_cfg.hit_low;
            trig[2] = hits_n >= cur_cfg.hit_high;
            trig[3] = hits_s >= cur_cfg.hit_high;
            trig[4] = lowb && vd <= cur_cfg.win_narrow;
            trig[5] = lowb && vd <= cur_cfg.win_middle;
            trig[6] = lowb && vd <= cur_cfg.win_wide;
            trig[7] = highb && vd <= cur_cfg.win_narrow;
            trig[8] = highb && vd <= cur_cfg.win_middle;
            trig[9] = highb && vd <= cur_cfg.win_wide;
            r.hits_north = 7'(hits_n);
            r.hits_south = 7'(hits_s);
            r.time_sum_north = 15'(tsum_n);
            r.time_sum_south = 15'(tsum_s);
            r.time_avg_north = 15'(avg_n);
            r.time_avg_south = 15'(avg_s);
            r.time_rem_north = 8'(rem_n);
            r.time_rem_south = 8'(rem_s);
            r.vertex_diff = 9'(vd);
            r.vertex_sum = 10'((avg_n + avg_s) & 'h3ff);
            r.trigger_bits = 10'(trig);
            r.slice_index = 6'(it.sample_index - cur_cfg.delay);
            results_due.insert(results_due.size(), r);
        end
        hits_n = 0; hits_s = 0; tsum_n = 0; tsum_s = 0;
    endfunction

    function automatic bit send_gap();
        case (idle_mode)
            1: return $urandom_range(99) < 62;
            3: return $urandom_range(99) < 21;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (idle_mode)
            2: return $urandom_range(99) < 62;
            3: return $urandom_range(99) < 21;
            default: return 1'b0;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) predict_beat(in_ch.item);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_beats.size() > 0 && !send_gap()) begin
                    in_ch.item <= pending_beats.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int got, int want);
        if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_out_item w, g;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                g = out_ch.item;
                if (results_due.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    w = results_due.pop_front();
                    check_field("hits_north", g.hits_north, w.hits_north);
                    check_field("hits_south", g.hits_south, w.hits_south);
                    check_field("time_sum_north", g.time_sum_north, w.time_sum_north);
                    check_field("time_sum_south", g.time_sum_south, w.time_sum_south);
                    check_field("time_avg_north", g.time_avg_north, w.time_avg_north);
                    check_field("time_avg_south", g.time_avg_south, w.time_avg_south);
                    check_field("time_rem_north", g.time_rem_north, w.time_rem_north);
                    check_field("time_rem_south", g.time_rem_south, w.time_rem_south);
                    check_field("vertex_diff", g.vertex_diff, w.vertex_diff);
                    check_field("vertex_sum", g.vertex_sum, w.vertex_sum);
                    check_field("trigger_bits", g.trigger_bits, w.trigger_bits);
                    check_field("slice_index", g.slice_index, w.slice_index);
                end
            end
            out_ch.ready <= !recv_stall();
        end
    end

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'($urandom_range(255));
            2: return 16'($urandom_range(16383, 8192));
            3: return 16'h3fff;
            4: return 16'($urandom_range(65535, 16384));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_in_item sample_beat(int pair, int s, int tv = -1, int qv = -1);
        t_in_item it;
        it.req_type = REQ_SAMPLE;
        it.pair_index = 7'(pair);
        it.sample_index = 6'(s);
        it.time_sample = (tv < 0) ? pick_raw() : 16'(tv);
        it.charge_sample = (qv < 0) ? pick_raw() : 16'(qv);
        it.table_address = 12'($urandom_range(4095));
        it.table_data = 10'($urandom_range(1023));
        return it;
    endfunction

    function automatic t_in_item table_beat(logic [1:0] req, int addr, int data);
        t_in_item it;
        it = sample_beat($urandom_range(127), $urandom_range(63));
        it.req_type = req;
        it.table_address = 12'(addr);
        it.table_data = 10'(data);
        return it;
    endfunction

    task automatic load_directed();
        queue_beat(table_beat(REQ_ADC_WR, 1023, 1023));
        queue_beat(table_beat(REQ_ADC_WR, 1024, 0));
        queue_beat(table_beat(REQ_ADC_WR, 4095, 5));
        queue_beat(table_beat(REQ_SLEW_WR, 4095, 1023));
        queue_beat(table_beat(REQ_SLEW_WR, 0, 0));
        queue_beat(table_beat(REQ_UNUSED, 7, 7));
        queue_beat(sample_beat(0, 0, 0, 0));
        queue_beat(sample_beat(64, 0, 0, 0));
        queue_beat(sample_beat(127, 0, 0, 0));
        // big step against zero pedestal gives hits on both sides
        queue_beat(sample_beat(0, 3, 65535, 65535));
        queue_beat(sample_beat(63, 3, 16384, 16383));
        queue_beat(sample_beat(64, 3, 16383, 0));
        queue_beat(sample_beat(127, 3, 9000, 20000));
        queue_beat(sample_beat(127, 4, 0, 0));
        queue_beat(sample_beat(0, 29, 30000, 1));
        queue_beat(sample_beat(127, 29));
        queue_beat(sample_beat(127, 30));
        queue_beat(sample_beat(127, 63, 65535, 65535));
        queue_beat(sample_beat(127, 2));
    endtask

    task automatic load_random(int count);
        int added, n, s0, sel;
        int plist[5];
        added = 0;
        while (added < count) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                // a sweep of samples over a few pairs, each sample ending the slice
                n = $urandom_range(5, 1);
                foreach (plist[k]) plist[k] = $urandom_range(126);
                s0 = $urandom_range(3);
                for (int s = s0; s < 64 && s <= cur_cfg.samples_per_event + 1; s++) begin
                    for (int k = 0; k < n; k++) queue_beat(sample_beat(plist[k], s));
                    queue_beat(sample_beat(PAIRS-1, s));
                    added += n + 1;
                end
            end else if (sel < 85) begin
                queue_beat(sample_beat(($urandom_range(3) == 0) ? PAIRS-1 :
                    $urandom_range(127), $urandom_range(63)));
                added++;
            end else if (sel < 93) begin
                queue_beat(table_beat(REQ_ADC_WR, $urandom_range(4095),
                    $urandom_range(1023)));
                added++;
            end else if (sel < 98) begin
                queue_beat(table_beat(REQ_SLEW_WR, $urandom_range(4095),
                    $urandom_range(1023)));
                added++;
            end else begin
                queue_beat(table_beat(REQ_UNUSED, $urandom_range(4095),
                    $urandom_range(1023)));
            end
        end
    endtask

    task automatic write_regs(int v[7]);
        logic [2:0] idx [7] = '{CFG_HIT_LOW, CFG_HIT_HIGH, CFG_WIN_NAR, CFG_WIN_MID,
                                CFG_WIN_WIDE, CFG_SPE, CFG_DELAY};
        for (int k = 0; k < 7; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= 9'(v[k]);
            do @(posedge i_clk); while (!cfg_ready);
            case (idx[k])
                CFG_HIT_LOW: cur_cfg.hit_low = 7'(v[k]);
                CFG_HIT_HIGH: cur_cfg.hit_high = 7'(v[k]);
                CFG_WIN_NAR: cur_cfg.win_narrow = 9'(v[k]);
                CFG_WIN_MID: cur_cfg.win_middle = 9'(v[k]);
                CFG_WIN_WIDE: cur_cfg.win_wide = 9'(v[k]);
                CFG_SPE: cur_cfg.samples_per_event = 6'(v[k]);
                default: cur_cfg.delay = 3'(v[k]);
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_beats.size() > 0 || in_ch.valid || results_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int settings[6][7];
        in_ch.valid = 1'b0;
        in_ch.item = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < PAIRS*HDEPTH; i++) hist_mem[i] = '0;
        for (int i = 0; i < 1024; i++) adc_lut[i] = 10'(i);
        for (int i = 0; i < 4096; i++) slew_lut[i] = 9'(i);
        hits_n = 0; hits_s = 0; tsum_n = 0; tsum_s = 0;
        cur_cfg = '{hit_low: 2, hit_high: 5, win_narrow: 10, win_middle: 20, win_wide: 30,
                    samples_per_event: 31, delay: 3};
        settings[0] = '{2, 5, 10, 20, 30, 31, 3};
        settings[1] = '{0, 0, 0, 0, 0, 8, 1};
        settings[2] = '{64, 64, 511, 511, 511, 63, 7};
        settings[3] = '{1, 3, 5, 40, 200, 12, 2};
        settings[4] = '{0, 127, 100, 300, 511, 0, 0};
        for (int k = 0; k < 7; k++) settings[5][k] = $urandom_range(511);
        settings[5][5] = $urandom_range(63, 1);
        settings[5][6] = $urandom_range(7, 1);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            @(posedge i_clk);
            write_regs(settings[p]);
            idle_mode = p % 4;
            if (p == 0) load_directed();
            load_random((p == 4) ? 60 : 240);
            wait_drained();
        end
        if (fails == 0) begin
            $display("vertex_trigger_primitive_engine_top verification clean");
        end else begin
            $display("vertex_trigger_primitive_engine_top verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("vertex_trigger_primitive_engine_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vtp_pkg.sv
rtl/vtp_ifs.sv
rtl/vtp_queue.sv
rtl/vtp_front.sv
rtl/vtp_divider.sv
rtl/vtp_back.sv
rtl/vertex_trigger_primitive_engine_top.sv
tb/testbench.sv
